### rtl/sha256hs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream engine package
// Beat types, operation codes, round constants and the SHA-256 bit functions
// shared by the byte-stream hashing engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256hs_pkg;

  // Operation carried by an input beat.
  localparam logic OP_ABSORB   = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;

  localparam int unsigned DigestWords = 8;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned Rounds      = 64;

  // Byte position in a block where the message length field begins.
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [7:0] PAD_MARKER = 8'h80;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_beat_t;

  localparam logic [31:0] INIT_H [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Big sigma functions of the round.
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Small sigma functions of the message schedule.
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) | (c & (a | b));
  endfunction

endpackage

### rtl/sha256_hash_stream.sv
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hashing engine
// Absorbs a message one byte per beat and, on a finalize beat, pads the
// message and returns the 256-bit digest as eight 32-bit word beats.
// ----------------------------------------------------------------------------
// An absorb beat that completes a 64-byte block makes the engine busy: it
// runs 64 rounds through a single round unit (one round per cycle) and then
// a fold step that adds the working variables into the chaining words, and
// the input stalls meanwhile. A finalize beat writes the padding one byte per
// cycle through the same byte packer (9 to 72 bytes, depending on how full
// the current block is), runs one or two compressions, and then presents
// the digest as eight output beats, H0 first, with last set on the eighth.
// The input channel stalls from the finalize beat until the eighth digest
// beat has been taken; after that the engine holds the standard initial hash
// value again and is ready for the next message. The message length is
// counted in bytes in a 32-bit counter that wraps, so the length field
// carries the low 35 bits of the bit count.
`timescale 1ns / 1ps

module sha256_hash_stream (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sha256hs_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sha256hs_pkg::out_beat_t out_data_o
);
  import sha256hs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // taking message bytes
  localparam logic [2:0] ST_PAD  = 3'd1;  // writing padding and length bytes
  localparam logic [2:0] ST_COMP = 3'd2;  // one compression round per cycle
  localparam logic [2:0] ST_FOLD = 3'd3;  // add working variables into the chain
  localparam logic [2:0] ST_EMIT = 3'd4;  // present the digest words

  logic [2:0]  state_q, state_d;

  // Chaining words H0..H7 and working variables a..h.
  logic [31:0] chain_q [DigestWords];
  logic [31:0] chain_d [DigestWords];
  logic [31:0] vars_q  [DigestWords];
  logic [31:0] vars_d  [DigestWords];

  // Message schedule window: win_q[0] is the word used by the current round,
  // win_q[15] the most recently entered one.
  logic [31:0] win_q [BlockWords];
  logic [31:0] win_d [BlockWords];

  // The first three bytes of a word wait here until the fourth arrives.
  logic [23:0] acc_q, acc_d;

  logic [31:0] byte_total_q, byte_total_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;

  // Padding control: pad_q is set for the whole finalize sequence, first_q
  // selects the marker byte, len_phase_q marks that the length field is being
  // written, and len_q shifts the 64-bit length out MSB first.
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        len_phase_q, len_phase_d;
  logic [63:0] len_q, len_d;

  logic        in_acc;
  logic        out_acc;
  logic        byte_en;
  logic [7:0]  byte_val;
  logic        win_shift;
  logic [31:0] win_new;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign out_data_o.digest_word = chain_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last        = (out_idx_q == 3'(DigestWords - 1));

  // Shared round unit and schedule expansion.
  assign sched_new = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
  assign t1 = vars_q[7] + bsig1(vars_q[4]) + ch_f(vars_q[4], vars_q[5], vars_q[6])
            + ROUND_K[round_q] + win_q[0];
  assign t2 = bsig0(vars_q[0]) + maj_f(vars_q[0], vars_q[1], vars_q[2]);

  // Byte source: message bytes while idle, generated bytes while padding.
  always_comb begin
    byte_en     = 1'b0;
    byte_val    = 8'h00;
    first_d     = first_q;
    len_phase_d = len_phase_q;
    len_d       = len_q;
    if (state_q == ST_IDLE) begin
      byte_en  = in_acc && (in_data_i.op == OP_ABSORB);
      byte_val = in_data_i.data_byte;
      if (in_acc && (in_data_i.op == OP_FINALIZE)) begin
        first_d     = 1'b1;
        len_phase_d = 1'b0;
        len_d       = {29'd0, byte_total_q, 3'b000};
      end
    end else if (state_q == ST_PAD) begin
      byte_en = 1'b1;
      if (first_q) begin
        byte_val = PAD_MARKER;
        first_d  = 1'b0;
      end else if (len_phase_q || (fill_q == LEN_START)) begin
        byte_val    = len_q[63:56];
        len_d       = len_q << 8;
        len_phase_d = 1'b1;
      end else begin
        byte_val = 8'h00;
      end
    end else if (state_q == ST_EMIT) begin
      // Once the digest is taken the length field belongs to no message.
      if (out_acc && out_data_o.last) begin
        len_phase_d = 1'b0;
      end
    end
  end

  // Schedule window: a packed word enters on the fourth byte of each word,
  // and every round shifts one expanded word in.
  always_comb begin
    win_shift = 1'b0;
    win_new   = sched_new;
    acc_d     = acc_q;
    if (byte_en) begin
      if (fill_q[1:0] == 2'b11) begin
        win_shift = 1'b1;
        win_new   = {acc_q, byte_val};
      end else begin
        acc_d = {acc_q[15:0], byte_val};
      end
    end else if (state_q == ST_COMP) begin
      win_shift = 1'b1;
    end
    for (int i = 0; i < BlockWords; i++) begin
      win_d[i] = win_q[i];
    end
    if (win_shift) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[BlockWords - 1] = win_new;
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    chain_d      = chain_q;
    vars_d       = vars_q;
    byte_total_d = byte_total_q;
    fill_d       = fill_q;
    round_d      = round_q;
    out_idx_d    = out_idx_q;
    pad_d        = pad_q;

    if (in_acc) begin
      if (in_data_i.op == OP_ABSORB) begin
        byte_total_d = byte_total_q + 32'd1;
      end else begin
        pad_d   = 1'b1;
        state_d = ST_PAD;
      end
    end

    if (byte_en) begin
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'd63) begin
        // Block complete: load the working variables and start the rounds.
        vars_d  = chain_q;
        round_d = 6'd0;
        state_d = ST_COMP;
      end
    end

    case (state_q)
      ST_COMP: begin
        vars_d[7] = vars_q[6];
        vars_d[6] = vars_q[5];
        vars_d[5] = vars_q[4];
        vars_d[4] = vars_q[3] + t1;
        vars_d[3] = vars_q[2];
        vars_d[2] = vars_q[1];
        vars_d[1] = vars_q[0];
        vars_d[0] = t1 + t2;
        round_d   = round_q + 6'd1;
        if (round_q == 6'(Rounds - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < DigestWords; i++) begin
          chain_d[i] = chain_q[i] + vars_q[i];
        end
        // The length field ends a block, so a finished length means done.
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (len_phase_q) begin
          out_idx_d = 3'd0;
          state_d   = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_data_o.last) begin
            chain_d      = INIT_H;
            byte_total_d = 32'd0;
            fill_d       = 6'd0;
            pad_d        = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_IDLE, ST_PAD: begin
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      chain_q      <= INIT_H;
      byte_total_q <= 32'd0;
      fill_q       <= 6'd0;
      round_q      <= 6'd0;
      out_idx_q    <= 3'd0;
      pad_q        <= 1'b0;
      first_q      <= 1'b0;
      len_phase_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      chain_q      <= chain_d;
      byte_total_q <= byte_total_d;
      fill_q       <= fill_d;
      round_q      <= round_d;
      out_idx_q    <= out_idx_d;
      pad_q        <= pad_d;
      first_q      <= first_d;
      len_phase_q  <= len_phase_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
    acc_q  <= acc_d;
    len_q  <= len_d;
  end

  // The digest is only presented once the padded message ends on a block edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q == 6'd0 && pad_q && len_phase_q))
    else $error("digest presented before padding finished");

  // A digest sequence always starts right after a fold of the last block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_FOLD))
    else $error("digest output did not follow a compression");

  // After the final digest beat the engine is back at its initial state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.last) |=>
      (chain_q[0] == INIT_H[0] && byte_total_q == 32'd0 && state_q == ST_IDLE))
    else $error("engine not re-initialized after digest");

  // The length field is only written within a finalize sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_phase_q && state_q != ST_IDLE) |-> pad_q)
    else $error("length field written outside finalize");

endmodule
